// ===== hdl/bm25_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BM25 block-max norm package
// Shared widths, the controller state type and the command/status bundles.
// ----------------------------------------------------------------------------
package bm25_pkg;

  localparam int BLOCK_ENTRIES = 128;
  localparam int FILL_W        = $clog2(BLOCK_ENTRIES);

  localparam int TF_W   = 16;
  localparam int LEN_W  = 16;
  localparam int AVG_W  = 24;
  localparam int NORM_W = 16;

  // tf * avg product, scaled numerator and denominator widths
  localparam int PROD_W = TF_W + AVG_W;
  localparam int NUM_W  = PROD_W + 5;
  localparam int DEN_W  = PROD_W + 4;

  // one quotient bit per divider step
  localparam int QSTEPS = NORM_W;
  localparam int STEP_W = $clog2(QSTEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/bm25_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BM25 block-max norm controller
// Sequences load, operand preparation, the divider steps and the max update.
// ----------------------------------------------------------------------------
module bm25_ctrl
  import bm25_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              last_step;

  assign last_step = (step_q == STEP_W'(QSTEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        step_d = step_q + STEP_W'(1);
        if (last_step) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold while a result is due and the output slot is still occupied
        if (!status_i.emit || status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_FIN: begin
        cmd_o.finish = !status_i.emit || status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== hdl/bm25_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BM25 block-max norm datapath
// Multiplier, restoring divider, block/term maxima and the output register.
// ----------------------------------------------------------------------------
module bm25_datapath
  import bm25_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [AVG_W-1:0]  cfg_data_i,
  input  logic [TF_W-1:0]   term_freq_i,
  input  logic [LEN_W-1:0]  doc_len_i,
  input  logic              doc_len_known_i,
  input  logic              term_end_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [NORM_W-1:0] block_max_norm_o,
  output logic [NORM_W-1:0] term_max_norm_o,
  output logic              last_o
);

  logic [AVG_W-1:0]  avg_q;
  logic [TF_W-1:0]   tf_q;
  logic [LEN_W-1:0]  len_q;
  logic              use_len_q;
  logic              end_q;
  logic [PROD_W-1:0] prod_q;

  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [QSTEPS-1:0] nlow_q;
  logic [NORM_W-1:0] quo_q;

  logic [FILL_W-1:0] fill_q;
  logic [NORM_W-1:0] bmax_q;
  logic [NORM_W-1:0] tmax_q;

  logic              out_valid_q;
  logic [NORM_W-1:0] out_block_q;
  logic [NORM_W-1:0] out_term_q;
  logic              out_last_q;

  logic [NUM_W-1:0]  num_d;
  logic [DEN_W-1:0]  den_d;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_diff;
  logic [NORM_W-1:0] bmax_new;
  logic [NORM_W-1:0] tmax_new;
  logic              emit;
  logic              out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (cfg_valid_i) begin
      avg_q <= cfg_data_i;
    end
  end

  // capture the entry and form tf * avg
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tf_q      <= term_freq_i;
      len_q     <= doc_len_i;
      use_len_q <= doc_len_known_i && (avg_q != '0);
      end_q     <= term_end_i;
      prod_q    <= PROD_W'(term_freq_i) * PROD_W'(avg_q);
    end
  end

  // numerator 22*tf*A (or 22*tf) and denominator as shift-add sums
  always_comb begin
    if (use_len_q) begin
      num_d = NUM_W'({prod_q, 4'b0000}) + NUM_W'({prod_q, 2'b00})
            + NUM_W'({prod_q, 1'b0});
      den_d = DEN_W'({prod_q, 3'b000}) + DEN_W'({prod_q, 1'b0})
            + DEN_W'({avg_q, 1'b0}) + DEN_W'(avg_q)
            + DEN_W'({len_q, 11'd0}) + DEN_W'({len_q, 8'd0});
    end else begin
      num_d = NUM_W'({tf_q, 4'b0000}) + NUM_W'({tf_q, 2'b00})
            + NUM_W'({tf_q, 1'b0});
      den_d = DEN_W'({tf_q, 3'b000}) + DEN_W'({tf_q, 1'b0}) + DEN_W'(12);
    end
  end

  // restoring divider over num * 2^14; the quotient fits NORM_W bits
  assign rem_sh   = {rem_q, nlow_q[QSTEPS-1]};
  assign rem_diff = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      den_q  <= den_d;
      rem_q  <= DEN_W'(num_d[NUM_W-1:2]);
      nlow_q <= {num_d[1:0], {(QSTEPS - 2){1'b0}}};
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      nlow_q <= {nlow_q[QSTEPS-2:0], 1'b0};
      if (!rem_diff[DEN_W]) begin
        rem_q <= rem_diff[DEN_W-1:0];
        quo_q <= {quo_q[NORM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DEN_W-1:0];
        quo_q <= {quo_q[NORM_W-2:0], 1'b0};
      end
    end
  end

  assign bmax_new = (quo_q > bmax_q) ? quo_q : bmax_q;
  assign tmax_new = (bmax_new > tmax_q) ? bmax_new : tmax_q;
  assign emit     = end_q || (fill_q == FILL_W'(BLOCK_ENTRIES - 1));
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.emit     = emit;
  assign status_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bmax_q <= '0;
      tmax_q <= '0;
    end else if (cmd_i.finish) begin
      if (emit) begin
        fill_q <= '0;
        bmax_q <= '0;
        tmax_q <= end_q ? '0 : tmax_new;
      end else begin
        fill_q <= fill_q + FILL_W'(1);
        bmax_q <= bmax_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && emit) begin
      out_block_q <= bmax_new;
      out_term_q  <= end_q ? tmax_new : '0;
      out_last_q  <= end_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign block_max_norm_o = out_block_q;
  assign term_max_norm_o  = out_term_q;
  assign last_o           = out_last_q;

  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && emit |-> out_free)
    else $error("result loaded while output slot busy");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> rem_q < den_q)
    else $error("divider remainder out of range");

  a_term_ge_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_term_q >= out_block_q)
    else $error("term max below block max");

  a_open_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_term_q == '0)
    else $error("term max set on a block that does not close the term");

endmodule

// ===== hdl/bm25_block_max_tf_norm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BM25 block-max term-frequency norm core
// Per-block and per-term upper bound of the BM25 tf norm, Q2.14 output.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes the average field length (Q16.8); zero turns length
//   normalization off. Write it only while the core is idle. cfg_ready_o is
//   always high.
//   The slave stream carries one posting entry per transfer; tlast marks the
//   last entry of a term and tuser says whether doc_len is known.
//   The master stream carries one result per closed block of BLOCK_ENTRIES
//   entries or per term end; tlast marks the block that closes the term.
// Sequence:
//   Each entry passes through the tf * avg multiply, the numerator and
//   denominator adds, 16 steps of the radix-2 restoring divider (one
//   quotient bit each) and the max update. No new entry is taken before
//   that update; a due result appears in the cycle after it.
// Reset and stall:
//   Reset clears the average length, the output valid flag, the fill count
//   and both maxima. A stalled master holds its result; the core keeps taking
//   entries until the next result is due, then waits in the update step until the slot drains.
// ----------------------------------------------------------------------------
module bm25_block_max_tf_norm_core
  import bm25_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [AVG_W-1:0]      cfg_data_i,      // average field length, Q16.8

  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [TF_W+LEN_W-1:0] s_axis_tdata_i,  // [15:0] term_freq, [31:16] doc_len
  input  logic                  s_axis_tuser_i,  // doc_len_known
  input  logic                  s_axis_tlast_i,  // term_end

  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [2*NORM_W-1:0]   m_axis_tdata_o,  // [15:0] block_max_norm, [31:16] term_max_norm
  output logic                  m_axis_tlast_o   // last
);

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [NORM_W-1:0] blk_max_norm;
  logic [NORM_W-1:0] term_max;

  assign cfg_ready_o = 1'b1;

  bm25_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bm25_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .term_freq_i      (s_axis_tdata_i[TF_W-1:0]),
    .doc_len_i        (s_axis_tdata_i[TF_W+LEN_W-1:TF_W]),
    .doc_len_known_i  (s_axis_tuser_i),
    .term_end_i       (s_axis_tlast_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .block_max_norm_o (blk_max_norm),
    .term_max_norm_o  (term_max),
    .last_o           (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {term_max, blk_max_norm};

endmodule
